// ===== sv/sapt_pkg.sv =====
// shared widths, constants and register indexes for the sample average plot tracer
package sapt_pkg;

	localparam int SAMPLE_W   = 12;
	localparam int AVG_W      = 12;
	localparam int SUM_W      = 18;
	localparam int ROW_W      = 8;
	localparam int COL_W      = 10;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 12;

	localparam logic [ROW_W-1:0] ROW_BASE = 8'd240;

	// avg / 18 as (avg * 3641) >> 16, exact for every 12-bit avg
	localparam int               ROW_RECIP_W     = 13;
	localparam logic [ROW_RECIP_W-1:0] ROW_RECIP = 13'd3641;
	localparam int               ROW_RECIP_SHIFT = 16;

	localparam logic [SAMPLE_W-1:0] THRESHOLD_RESET  = 12'd2000;
	localparam logic [COL_W-1:0]    PLOT_WIDTH_RESET = 10'd320;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_LEVEL_THRESHOLD = 1'b0,
		CFG_PLOT_WIDTH      = 1'b1
	} cfg_index_t;

endpackage

// ===== sv/sample_average_plot_tracer.sv =====
// sample average plot tracer: block averaging, level flag and plot trace segments
//
// Takes one 12-bit sample per cycle while in_valid is high and in_stall is low. Every
// AVG_COUNT samples close a block. The edge that takes the block's last sample latches
// the block sum in stage s1. The average, formed by a multiply by the reciprocal of
// AVG_COUNT, is then latched in stage s2; the plot row, formed by a multiply by the
// reciprocal of 18, is then latched in the output stage together with the level compare
// and the column step. Only the last sample of a block can be stalled, and only when the
// three result stages are all full. level_threshold and plot_width are written through
// cfg_we/cfg_index/cfg_data; the user must write them only while no block is in flight,
// as the block itself does not enforce it.
module sample_average_plot_tracer #(
	parameter int AVG_COUNT = 8
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic [sapt_pkg::SAMPLE_W-1:0]   sample,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic [sapt_pkg::AVG_W-1:0]      block_average,
	output logic                            level_flag,
	output logic [sapt_pkg::ROW_W-1:0]      row,
	output logic [sapt_pkg::ROW_W-1:0]      row_before,
	output logic [sapt_pkg::COL_W-1:0]      column,
	output logic                            clear_screen,
	input  logic                            cfg_we,
	input  logic [sapt_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [sapt_pkg::CFG_DATA_W-1:0] cfg_data
);
	import sapt_pkg::*;

	localparam int CNT_W       = $clog2(AVG_COUNT);
	localparam int RECIP_SHIFT = SUM_W + CNT_W;
	localparam int RECIP_W     = SUM_W + 1;
	localparam int RECIP_MUL   = ((1 << RECIP_SHIFT) + AVG_COUNT - 1) / AVG_COUNT;
	localparam int PROD_W      = SUM_W + RECIP_W;
	localparam int ROW_PROD_W  = AVG_W + ROW_RECIP_W;

	localparam logic [CNT_W-1:0]   CNT_LAST  = CNT_W'(AVG_COUNT - 1);
	localparam logic [RECIP_W-1:0] RECIP_VAL = RECIP_W'(RECIP_MUL);

	logic [SAMPLE_W-1:0] threshold_q;
	logic [COL_W-1:0]    plot_width_q;

	logic [SUM_W-1:0]    acc_q;
	logic [CNT_W-1:0]    cnt_q;
	logic [COL_W-1:0]    col_q;
	logic [ROW_W-1:0]    last_row_q;

	logic                s1_valid_q;
	logic [SUM_W-1:0]    sum_s1;
	logic                s2_valid_q;
	logic [AVG_W-1:0]    avg_s2;

	logic                out_valid_q;
	logic [AVG_W-1:0]    avg_q;
	logic                level_q;
	logic [ROW_W-1:0]    row_q;
	logic [ROW_W-1:0]    row_before_q;
	logic [COL_W-1:0]    column_q;
	logic                clear_q;

	logic                out_ready;
	logic                s2_ready;
	logic                s1_ready;
	logic                block_end;
	logic                in_take;
	logic [SUM_W-1:0]    acc_next;
	logic [PROD_W-1:0]   avg_prod;
	logic [ROW_PROD_W-1:0] row_prod;
	logic [ROW_W-1:0]    row_next;
	logic [COL_W:0]      col_inc;
	logic                wrap;

	// stage hand-off, each stage frees when the one below moves
	assign out_ready = !out_valid_q || !out_stall;
	assign s2_ready  = !s2_valid_q || out_ready;
	assign s1_ready  = !s1_valid_q || s2_ready;

	assign block_end = (cnt_q == CNT_LAST);
	assign in_stall  = block_end && !s1_ready;
	assign in_take   = in_valid && !in_stall;
	assign acc_next  = acc_q + SUM_W'(sample);

	assign avg_prod = {{RECIP_W{1'b0}}, sum_s1} * {{SUM_W{1'b0}}, RECIP_VAL};
	assign row_prod = {{ROW_RECIP_W{1'b0}}, avg_s2} * {{AVG_W{1'b0}}, ROW_RECIP};
	assign row_next = ROW_BASE - row_prod[ROW_RECIP_SHIFT +: ROW_W];
	assign col_inc  = {1'b0, col_q} + {{COL_W{1'b0}}, 1'b1};
	assign wrap     = col_inc >= {1'b0, plot_width_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			threshold_q  <= THRESHOLD_RESET;
			plot_width_q <= PLOT_WIDTH_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index_t'(cfg_index))
				CFG_LEVEL_THRESHOLD: threshold_q  <= cfg_data;
				CFG_PLOT_WIDTH:      plot_width_q <= cfg_data[COL_W-1:0];
				default: ;
			endcase
		end
	end

	// accumulator and block counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
			cnt_q <= '0;
		end else if (in_take) begin
			if (block_end) begin
				acc_q <= '0;
				cnt_q <= '0;
			end else begin
				acc_q <= acc_next;
				cnt_q <= cnt_q + CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
			s2_valid_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (s1_ready) begin
				s1_valid_q <= in_take && block_end;
			end
			if (s2_ready) begin
				s2_valid_q <= s1_valid_q;
			end
			if (out_ready) begin
				out_valid_q <= s2_valid_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_take && block_end) begin
			sum_s1 <= acc_next;
		end
		if (s1_valid_q && s2_ready) begin
			avg_s2 <= avg_prod[RECIP_SHIFT +: AVG_W];
		end
		if (s2_valid_q && out_ready) begin
			avg_q        <= avg_s2;
			level_q      <= avg_s2 > threshold_q;
			row_q        <= row_next;
			row_before_q <= last_row_q;
			column_q     <= col_q;
			clear_q      <= wrap;
		end
	end

	// plot trace state steps once per finished block
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q      <= '0;
			last_row_q <= '0;
		end else if (s2_valid_q && out_ready) begin
			col_q      <= wrap ? '0 : col_inc[COL_W-1:0];
			last_row_q <= row_next;
		end
	end

	assign out_valid     = out_valid_q;
	assign block_average = avg_q;
	assign level_flag    = level_q;
	assign row           = row_q;
	assign row_before    = row_before_q;
	assign column        = column_q;
	assign clear_screen  = clear_q;

endmodule

// ===== sv/sapt_checker.sv =====
// port-level assertions for the sample average plot tracer, bound to the top level
module sapt_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            out_valid,
	input logic                            out_stall,
	input logic [sapt_pkg::AVG_W-1:0]      block_average,
	input logic [sapt_pkg::ROW_W-1:0]      row,
	input logic [sapt_pkg::ROW_W-1:0]      row_before,
	input logic [sapt_pkg::COL_W-1:0]      column,
	input logic                            clear_screen
);
	import sapt_pkg::*;

	logic [ROW_W-1:0] prev_row_q;
	logic [COL_W-1:0] exp_col_q;
	logic             out_take;

	assign out_take = out_valid && !out_stall;

	// shadow of the trace state as seen on the result port
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_row_q <= '0;
			exp_col_q  <= '0;
		end else if (out_take) begin
			prev_row_q <= row;
			exp_col_q  <= clear_screen ? '0 : column + COL_W'(1);
		end
	end

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(row) && $stable(block_average))
		else $error("stalled result item changed");

	a_row_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> row >= ROW_W'(13) && row <= ROW_BASE)
		else $error("row out of plot range");

	a_row_chain: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> row_before == prev_row_q)
		else $error("row_before does not match previous item's row");

	a_col_step: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> column == exp_col_q)
		else $error("column did not step or wrap correctly");

endmodule

bind sample_average_plot_tracer sapt_checker u_sapt_checker (.*);
